FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL that carries checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: property failed");
// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

FILE: sv/sapq_pkg.sv
// Types, codes and defaults for the sorted array priority queue.
// No dependencies.
package sapq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int CAP_W         = 5;
   localparam int OCC_W         = 5;

   // operation codes
   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // array read address select
   localparam logic [1:0] RD_ZERO = 2'd0;
   localparam logic [1:0] RD_K    = 2'd1;
   localparam logic [1:0] RD_PREV = 2'd2;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] item_value;
      logic [7:0]         item_priority;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] out_value;
      logic [OCC_W-1:0]   occupancy;
   } rsp_type;

   typedef struct packed {
      logic [7:0]         prio;
      logic signed [31:0] value;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic [1:0] rd_sel;
      logic       wr_en;
      logic       wr_at_prev;
      logic       wr_new;
      logic       k_load_count;
      logic       k_load_one;
      logic       k_dec;
      logic       k_inc;
      logic       load_result;
      logic       commit;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_deq;
      logic is_full;
      logic is_empty;
      logic k_zero;
      logic k_at_count;
      logic rd_greater;
   } dp_status_type;

endpackage

FILE: sv/sapq_datapath.sv
// Datapath: entry array, count, capacity, insertion index and result register.
// Depends on sapq_pkg.
module sapq_datapath
   import sapq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  logic          csr_we,
   input  logic [CAP_W-1:0] csr_data,
   input  ctl_cmd_type   cmd,
   output dp_status_type stat,
   output rsp_type       rsp_data
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

   entry_type          mem_ff [DEPTH];
   entry_type          rd_ff;
   req_type            req_ff;
   logic [CAP_W-1:0]   cap_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      k_ff, k_in;
   logic signed [31:0] result_ff;
   rsp_type            rsp_ff, rsp_in;

   logic [CW-1:0] k_prev;
   logic [AW-1:0] rd_addr, wr_addr;
   entry_type     wr_data;
   logic          is_full, is_empty, is_deq;

   // index arithmetic and array addressing
   assign k_prev  = k_ff - CW'(1);
   assign wr_addr = cmd.wr_at_prev ? k_prev[AW-1:0] : k_ff[AW-1:0];
   assign wr_data = cmd.wr_new ? entry_type'{prio: req_ff.item_priority,
                                             value: req_ff.item_value} : rd_ff;

   always_comb begin
      case (cmd.rd_sel)
         RD_K:    rd_addr = k_ff[AW-1:0];
         RD_PREV: rd_addr = k_prev[AW-1:0];
         default: rd_addr = '0;
      endcase
   end

   // full when count reaches the written capacity or the array depth
   assign is_full  = (CMPW'(count_ff) >= CMPW'(cap_ff)) || (count_ff >= CW'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign is_deq   = (req_ff.cmd == CMD_DEQUEUE);

   assign stat.is_deq     = is_deq;
   assign stat.is_full    = is_full;
   assign stat.is_empty   = is_empty;
   assign stat.k_zero     = (k_ff == '0);
   assign stat.k_at_count = (k_ff == count_ff);
   assign stat.rd_greater = (rd_ff.prio > req_ff.item_priority);

   // insertion / shift index
   always_comb begin
      k_in = k_ff;
      if (cmd.k_load_count) begin
         k_in = count_ff;
      end else if (cmd.k_load_one) begin
         k_in = CW'(1);
      end else if (cmd.k_dec) begin
         k_in = k_prev;
      end else if (cmd.k_inc) begin
         k_in = k_ff + CW'(1);
      end
   end

   // count after the operation, and the result beat
   always_comb begin
      count_in = count_ff;
      if (!is_deq && !is_full) begin
         count_in = count_ff + CW'(1);
      end else if (is_deq && !is_empty) begin
         count_in = count_ff - CW'(1);
      end
      if (is_deq) begin
         rsp_in.status = is_empty ? ST_EMPTY : ST_OK;
      end else begin
         rsp_in.status = is_full ? ST_FULL : ST_OK;
      end
      rsp_in.out_value = (is_deq && !is_empty) ? result_ff : 32'sd0;
      rsp_in.occupancy = OCC_W'(count_in);
   end

   // entry array: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= CAP_W'(16);
      end else begin
         if (cmd.commit) begin
            count_ff <= count_in;
         end
         if (csr_we) begin
            cap_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.load_result) begin
         result_ff <= rd_ff.value;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: sv/sapq_ctrl.sv
// Controller: sequences insertion and removal shifts over the entry array.
// Depends on sapq_pkg.
module sapq_ctrl
   import sapq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type stat,
   output ctl_cmd_type   cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECIDE   = 3'd1;
   localparam logic [2:0] S_ENQ_RD   = 3'd2;
   localparam logic [2:0] S_ENQ_CMP  = 3'd3;
   localparam logic [2:0] S_DEQ_HEAD = 3'd4;
   localparam logic [2:0] S_DEQ_RD   = 3'd5;
   localparam logic [2:0] S_DEQ_MV   = 3'd6;
   localparam logic [2:0] S_FIN      = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.is_deq) begin
               if (stat.is_empty) begin
                  state_in = S_FIN;
               end else begin
                  cmd.rd_sel = RD_ZERO;
                  state_in   = S_DEQ_HEAD;
               end
            end else if (stat.is_full) begin
               state_in = S_FIN;
            end else begin
               cmd.k_load_count = 1'b1;
               state_in         = S_ENQ_RD;
            end
         end
         S_ENQ_RD: begin
            if (stat.k_zero) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_new = 1'b1;
               state_in   = S_FIN;
            end else begin
               cmd.rd_sel = RD_PREV;
               state_in   = S_ENQ_CMP;
            end
         end
         S_ENQ_CMP: begin
            // move the larger entry up one place, or drop the new one in
            cmd.wr_en = 1'b1;
            if (stat.rd_greater) begin
               cmd.k_dec = 1'b1;
               state_in  = S_ENQ_RD;
            end else begin
               cmd.wr_new = 1'b1;
               state_in   = S_FIN;
            end
         end
         S_DEQ_HEAD: begin
            cmd.load_result = 1'b1;
            cmd.k_load_one  = 1'b1;
            state_in        = S_DEQ_RD;
         end
         S_DEQ_RD: begin
            if (stat.k_at_count) begin
               state_in = S_FIN;
            end else begin
               cmd.rd_sel = RD_K;
               state_in   = S_DEQ_MV;
            end
         end
         S_DEQ_MV: begin
            cmd.wr_en      = 1'b1;
            cmd.wr_at_prev = 1'b1;
            cmd.k_inc      = 1'b1;
            state_in       = S_DEQ_RD;
         end
         S_FIN: begin
            // wait for the output register to be free
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/sorted_array_priority_queue.sv
// Sorted array priority queue. One command in flight; the array moves one entry
// per read and write step through its single write and registered read port.
// A full enqueue or an empty dequeue goes straight to the result beat; an enqueue
// moves each entry of greater priority value up one place, a dequeue shifts the rest down.
// The next command is taken once the last has finished, even while its result waits.
// Synchronous active-high reset empties the queue and sets capacity to 16.
module sorted_array_priority_queue
   import sapq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data
);

`include "assert_macros.svh"

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_stat;

   assign csr_ready = 1'b1;

   sapq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (dp_stat),
      .cmd       (ctl_cmd)
   );

   sapq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr_we   (csr_valid && csr_ready),
      .csr_data (csr_data),
      .cmd      (ctl_cmd),
      .stat     (dp_stat),
      .rsp_data (rsp_data)
   );

   // an accepted beat keeps the block busy on the next cycle
   `ASSERT_CLK(a_busy_after_accept, clock, reset, req_valid && !req_stall |=> req_stall)
   // the array is only written while a command is in flight
   `ASSERT_NEVER(a_no_idle_write, clock, reset, ctl_cmd.wr_en && !req_stall)
   // a result is never loaded over one still waiting
   `ASSERT_NEVER(a_no_overwrite, clock, reset, ctl_cmd.commit && rsp_valid && rsp_stall)
   // an empty report carries no item and an empty queue
   `ASSERT_CLK(a_empty_result, clock, reset,
      rsp_valid && rsp_data.status == ST_EMPTY |->
      rsp_data.out_value == 32'sd0 && rsp_data.occupancy == '0)

endmodule

FILE: tb/sorted_array_priority_queue_test.sv
// Self-checking testbench for the sorted array priority queue.
// Needs sapq_pkg and sorted_array_priority_queue; a shadow copy of the queue
// predicts every response beat and a scoreboard class checks it.
`timescale 1ns / 1ps

module sorted_array_priority_queue_test;
   import sapq_pkg::*;

   localparam int CYCLE_LIMIT     = 500000;
   localparam int PHASE_COUNT     = 12;
   localparam int ITEMS_PER_PHASE = 155;
   localparam int SETTLE_CYCLES   = 40;

   // Shadow of the queue contents plus the responses still owed by the block
   class queue_shadow;
      entry_type        slots [DEPTH_DEFAULT];
      int               held_count = 0;
      logic [CAP_W-1:0] capacity   = 5'd16;
      rsp_type          owed_responses [$];
      int               error_count = 0;

      function void set_capacity(input logic [CAP_W-1:0] cap);
         capacity = cap;
      endfunction

      function int outstanding();
         return owed_responses.size();
      endfunction

      // Apply an accepted command beat to the shadow and queue its response
      function void note_command(input req_type beat);
         rsp_type outcome;
         int      usable;
         int      pos;
         int      k;
         outcome = '0;
         usable  = (capacity > DEPTH_DEFAULT) ? DEPTH_DEFAULT : int'(capacity);
         if (beat.cmd == CMD_ENQUEUE) begin
            if (held_count >= usable) begin
               outcome.status = ST_FULL;
            end else begin
               // insert behind every entry of equal or lower priority value
               pos = 0;
               while (pos < held_count && slots[pos].prio <= beat.item_priority) pos++;
               for (k = held_count; k > pos; k--) slots[k] = slots[k-1];
               slots[pos].prio  = beat.item_priority;
               slots[pos].value = beat.item_value;
               held_count++;
            end
         end else begin
            if (held_count == 0) begin
               outcome.status = ST_EMPTY;
            end else begin
               outcome.out_value = slots[0].value;
               for (k = 1; k < held_count; k++) slots[k-1] = slots[k];
               held_count--;
            end
         end
         outcome.occupancy = held_count[OCC_W-1:0];
         owed_responses.push_back(outcome);
      endfunction

      // Compare a response beat with the oldest owed response
      function void check_result(input rsp_type got);
         rsp_type want;
         if (owed_responses.size() == 0) begin
            $display("%0t: unexpected response beat status %0d value %0d occupancy %0d",
                     $time, got.status, got.out_value, got.occupancy);
            error_count++;
            return;
         end
         want = owed_responses.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            error_count++;
         end
         if (got.out_value !== want.out_value) begin
            $display("%0t: out_value expected %0d, got %0d",
                     $time, want.out_value, got.out_value);
            error_count++;
         end
         if (got.occupancy !== want.occupancy) begin
            $display("%0t: occupancy expected %0d, got %0d",
                     $time, want.occupancy, got.occupancy);
            error_count++;
         end
      endfunction
   endclass

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data  = '0;

   queue_shadow shadow;
   int          cycle_count = 0;
   int          stall_run   = 0;

   sorted_array_priority_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver back-pressure: short stalls, short free runs, now and then a long free run
   always @(posedge clock) begin
      if (stall_run > 0) begin
         stall_run--;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b1;
         stall_run = $urandom_range(0, 7);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) shadow.check_result(rsp_data);
   end

   // Present one command beat and hold it until the block takes it
   task automatic issue(input logic cmd, input logic signed [31:0] value,
                        input logic [7:0] prio);
      req_type beat;
      beat.cmd           = cmd;
      beat.item_value    = value;
      beat.item_priority = prio;
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      shadow.note_command(beat);
   endtask

   // Capacity is only changed once the block has drained every response
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      req_valid <= 1'b0;
      while (shadow.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow.set_capacity(cap);
   endtask

   initial begin
      logic [CAP_W-1:0]   caps [PHASE_COUNT];
      bit [PHASE_COUNT-1:0] fill_at_end;
      int                 ph;
      int                 i;
      int                 run_left;
      int                 enq_pct;
      int                 burst_left;
      int                 max_gap;
      int                 gap;
      logic               cmd;
      logic signed [31:0] value;
      logic [7:0]         prio;

      shadow = new();
      caps = '{5'd31, 5'd1, 5'd0, 5'd16, 5'd3, 5'd8, 5'd17, 5'd2,
               5'd0, 5'd16, 5'd5, 5'd0};
      caps[8]  = CAP_W'($urandom_range(0, 31));
      caps[11] = CAP_W'($urandom_range(0, 31));
      // phases that end by filling, so the next smaller capacity sits below the count
      fill_at_end = 12'b0000_0000_1001;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty dequeue, field extremes, ties at both priority ends
      issue(CMD_DEQUEUE, $urandom, 8'($urandom_range(0, 255)));
      issue(CMD_ENQUEUE, 32'sh7fff_ffff, 8'd255);
      issue(CMD_ENQUEUE, 32'sh8000_0000, 8'd0);
      issue(CMD_ENQUEUE, -32'sd1, 8'd255);
      issue(CMD_ENQUEUE, 32'sd0, 8'd128);
      issue(CMD_ENQUEUE, 32'sh5a5a_5a5a, 8'd0);
      repeat (6) issue(CMD_DEQUEUE, $urandom, 8'($urandom_range(0, 255)));

      // directed: small capacity, full on enqueue, refill, drain past empty
      write_capacity(5'd2);
      issue(CMD_ENQUEUE, 32'sd11, 8'd7);
      issue(CMD_ENQUEUE, 32'sd22, 8'd3);
      issue(CMD_ENQUEUE, 32'sd33, 8'd1);
      issue(CMD_DEQUEUE, $urandom, 8'($urandom_range(0, 255)));
      issue(CMD_ENQUEUE, 32'sd44, 8'd7);
      repeat (3) issue(CMD_DEQUEUE, $urandom, 8'($urandom_range(0, 255)));

      // random phases, each at its own capacity
      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         write_capacity(caps[ph]);
         max_gap    = (ph % 4 == 1) ? 0 : $urandom_range(1, 8);
         run_left   = 0;
         burst_left = $urandom_range(1, 12);
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            // runs that fill, drain or mix so the queue swings between full and empty
            if (run_left == 0) begin
               run_left = $urandom_range(8, 30);
               case ($urandom_range(0, 2))
                  0:       enq_pct = 85;
                  1:       enq_pct = 15;
                  default: enq_pct = 50;
               endcase
            end
            run_left--;
            if (fill_at_end[ph] && i >= ITEMS_PER_PHASE - 20) enq_pct = 100;
            cmd = ($urandom_range(1, 100) <= enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;

            case ($urandom_range(0, 7))
               0:       value = 32'sh8000_0000;
               1:       value = 32'sh7fff_ffff;
               2:       value = 32'sd0;
               3:       value = -32'sd1;
               default: value = $urandom;
            endcase
            // narrow priority bands give plenty of ties
            case ($urandom_range(0, 3))
               0:       prio = 8'($urandom_range(0, 255));
               1:       prio = 8'($urandom_range(0, 3));
               2:       prio = $urandom_range(0, 1) ? 8'd255 : 8'd0;
               default: prio = 8'($urandom_range(100, 103));
            endcase
            issue(cmd, value, prio);

            // sender bursts with gaps between them; the phase end drops valid itself
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
               if (gap > 0 && i < ITEMS_PER_PHASE - 1) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end else begin
               burst_left--;
            end
         end
      end

      req_valid <= 1'b0;
      while (shadow.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (shadow.error_count == 0 && shadow.outstanding() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: sorted_array_priority_queue.f
+incdir+sv
sv/sapq_pkg.sv
sv/sapq_datapath.sv
sv/sapq_ctrl.sv
sv/sorted_array_priority_queue.sv
tb/sorted_array_priority_queue_test.sv
